// ===== rtl/tcw_pkg.sv =====
package tcw_pkg;

	// Item kinds carried in s_tuser
	localparam logic [1:0] KIND_PUT   = 2'd0;
	localparam logic [1:0] KIND_CLEAR = 2'd1;
	localparam logic [1:0] KIND_READ  = 2'd2;

	// Control characters
	localparam logic [7:0] CHAR_BS    = 8'd8;
	localparam logic [7:0] CHAR_TAB   = 8'd9;
	localparam logic [7:0] CHAR_NL    = 8'd10;
	localparam logic [7:0] CHAR_ESC   = 8'd27;
	localparam logic [7:0] CHAR_SPACE = 8'h20;

	// Cell values: attribute in the high byte, character in the low byte
	localparam logic [15:0] BLANK_CELL = 16'h0720;
	localparam logic [15:0] TEXT_ATTR  = 16'h0700;

	// Fixed field widths of the stream words
	localparam int unsigned COL_OUT_W  = 7;
	localparam int unsigned ROW_OUT_W  = 5;
	localparam int unsigned POS_OUT_W  = 11;
	localparam int unsigned INDEX_W    = 11;
	localparam int unsigned CELL_W     = 16;

endpackage

// ===== rtl/tcw_cell_ram.sv =====
module tcw_cell_ram #(
	parameter int unsigned DEPTH = 2000,
	parameter int unsigned AW    = 11
) (
	input  logic                           clk,
	input  logic                           we,
	input  logic [AW-1:0]                  waddr,
	input  logic [tcw_pkg::CELL_W-1:0]     wdata,
	input  logic [AW-1:0]                  raddr,
	output logic [tcw_pkg::CELL_W-1:0]     rdata
);

	logic [tcw_pkg::CELL_W-1:0] mem [DEPTH];

	// One write port, one registered read port
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

// ===== rtl/text_console_writer.sv =====
// Text console writer: keeps a ROWS x COLS screen of 16-bit cells and a cursor.
// Input channel s_*: one word per item; s_tuser holds the kind (put character,
// clear screen, read cell), s_tdata holds the character and the cell index.
// Output channel m_*: one word per item with the cursor column, row and linear
// position after the item, the cell read (zero unless a read) and a flag that
// says the screen scrolled.
// Steps per item, from accept to result valid:
//   put character, escape or unused kind: execute, then finish
//   read one cell: execute, the registered RAM read (index in range), finish
//   clear screen: execute, blank every cell, one cell write per cycle, finish
//   character that scrolls: execute, then the move of ROWS-1 rows runs
//   one cell per cycle through the single RAM read and write port, then the
//   bottom row is blanked one cell per cycle, then finish.
// The block takes one item at a time; s_tready is high only when no item is
// in work. A finished word sits in the output register, and the next item is
// accepted while it waits for m_tready; a further result then waits in turn.
// Reset clears the cursor to row 0, column 0 and empties the output register.
// The screen memory holds no defined contents after reset; no clearing pass
// runs, so read only cells written since reset.
module text_console_writer #(
	parameter int unsigned COLS = 80,
	parameter int unsigned ROWS = 25
) (
	input  logic        clk,
	input  logic        arst_n,
	// Input words
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [23:0] s_tdata,   // char_code[7:0], cell_index[18:8], zero pad
	input  logic [1:0]  s_tuser,   // kind[1:0]
	// Result words
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [39:0] m_tdata    // cursor_col[6:0], cursor_row[11:7],
	                               // cursor_pos[22:12], cell_data[38:23],
	                               // scrolled[39]
);

	localparam int unsigned NCELLS    = COLS * ROWS;
	localparam int unsigned CW        = $clog2(COLS);
	localparam int unsigned RW        = $clog2(ROWS);
	localparam int unsigned AW        = $clog2(NCELLS);
	localparam logic [CW-1:0] COL_LAST  = CW'(COLS - 1);
	localparam logic [RW-1:0] ROW_LAST  = RW'(ROWS - 1);
	localparam logic [AW-1:0] POS_COLS  = AW'(COLS);
	localparam logic [AW-1:0] POS_CLAST = AW'(COLS - 1);
	localparam logic [AW-1:0] MOVE_LAST = AW'(NCELLS - COLS - 1);
	localparam logic [AW-1:0] CELL_LAST = AW'(NCELLS - 1);

	// Sequencer states
	localparam logic [2:0] ST_IDLE   = 3'd0;
	localparam logic [2:0] ST_EXEC   = 3'd1;
	localparam logic [2:0] ST_READ   = 3'd2;
	localparam logic [2:0] ST_SCROLL = 3'd3;
	localparam logic [2:0] ST_BLANK  = 3'd4;
	localparam logic [2:0] ST_FINISH = 3'd5;

	logic [2:0]                  state_q;
	logic [1:0]                  kind_q;
	logic [7:0]                  code_q;
	logic [tcw_pkg::INDEX_W-1:0] index_q;
	logic [CW-1:0]               col_q;
	logic [RW-1:0]               row_q;
	logic [AW-1:0]               pos_q;
	logic [AW-1:0]               cnt_q;
	logic                        scroll_q;
	logic [tcw_pkg::CELL_W-1:0]  data_q;
	logic                        pend_s1;
	logic [AW-1:0]               wa_s1;
	logic                        m_tvalid_q;
	logic [39:0]                 m_tdata_q;

	logic                        ram_we;
	logic [AW-1:0]               ram_waddr;
	logic [tcw_pkg::CELL_W-1:0]  ram_wdata;
	logic [AW-1:0]               ram_raddr;
	logic [tcw_pkg::CELL_W-1:0]  ram_rdata;

	logic                        s_accept;
	logic                        is_esc;
	logic                        is_nl;
	logic                        is_bs;
	logic                        read_ok;
	logic [7:0]                  put_byte;
	logic [AW:0]                 src_addr;

	assign s_tready = (state_q == ST_IDLE);
	assign s_accept = s_tvalid && s_tready;
	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = m_tdata_q;

	// Decode the held character
	assign is_esc   = (code_q == tcw_pkg::CHAR_ESC);
	assign is_nl    = (code_q == tcw_pkg::CHAR_NL);
	assign is_bs    = (code_q == tcw_pkg::CHAR_BS);
	assign put_byte = (code_q == tcw_pkg::CHAR_TAB) ? tcw_pkg::CHAR_SPACE : code_q;
	assign read_ok  = (32'(index_q) < NCELLS);
	assign src_addr = {1'b0, cnt_q} + {1'b0, POS_COLS};

	tcw_cell_ram #(
		.DEPTH(NCELLS),
		.AW   (AW)
	) u_ram (
		.clk  (clk),
		.we   (ram_we),
		.waddr(ram_waddr),
		.wdata(ram_wdata),
		.raddr(ram_raddr),
		.rdata(ram_rdata)
	);

	// Drive the RAM port from the sequencer
	always_comb begin
		ram_we    = 1'b0;
		ram_waddr = cnt_q;
		ram_wdata = tcw_pkg::BLANK_CELL;
		ram_raddr = AW'(index_q);
		case (state_q)
			ST_EXEC: begin
				if (kind_q == tcw_pkg::KIND_PUT) begin
					if (is_bs) begin
						ram_we    = (pos_q != '0);
						ram_waddr = pos_q - AW'(1);
					end else if (!is_esc && !is_nl) begin
						ram_we    = 1'b1;
						ram_waddr = pos_q;
						ram_wdata = tcw_pkg::TEXT_ATTR | {8'h00, put_byte};
					end
				end
			end
			ST_SCROLL: begin
				ram_raddr = src_addr[AW-1:0];
				ram_we    = pend_s1;
				ram_waddr = wa_s1;
				ram_wdata = ram_rdata;
			end
			ST_BLANK: begin
				ram_we = 1'b1;
				if (pend_s1) begin
					ram_waddr = wa_s1;
					ram_wdata = ram_rdata;
				end
			end
			default: begin
				ram_we = 1'b0;
			end
		endcase
	end

	// Capture the item payload
	always_ff @(posedge clk) begin
		if (s_accept) begin
			kind_q  <= s_tuser;
			code_q  <= s_tdata[7:0];
			index_q <= s_tdata[18:8];
		end
	end

	// Sequencer, cursor and result
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= ST_IDLE;
			col_q      <= '0;
			row_q      <= '0;
			pos_q      <= '0;
			cnt_q      <= '0;
			scroll_q   <= 1'b0;
			pend_s1    <= 1'b0;
			wa_s1      <= '0;
			data_q     <= '0;
			m_tvalid_q <= 1'b0;
			m_tdata_q  <= '0;
		end else begin
			// drop the result word once taken; finish reloads it instead
			if (m_tvalid_q && m_tready && (state_q != ST_FINISH)) begin
				m_tvalid_q <= 1'b0;
			end
			case (state_q)
				ST_IDLE: begin
					if (s_accept) begin
						scroll_q <= 1'b0;
						data_q   <= '0;
						state_q  <= ST_EXEC;
					end
				end
				ST_EXEC: begin
					cnt_q <= '0;
					case (kind_q)
						tcw_pkg::KIND_PUT: begin
							if (is_esc) begin
								state_q <= ST_FINISH;
							end else if (is_nl) begin
								col_q <= '0;
								if (row_q == ROW_LAST) begin
									pos_q    <= pos_q - AW'(col_q);
									scroll_q <= 1'b1;
									state_q  <= ST_SCROLL;
								end else begin
									row_q   <= row_q + RW'(1);
									pos_q   <= pos_q - AW'(col_q) + POS_COLS;
									state_q <= ST_FINISH;
								end
							end else if (is_bs) begin
								state_q <= ST_FINISH;
								if (pos_q != '0) begin
									pos_q <= pos_q - AW'(1);
									if (col_q == '0) begin
										col_q <= COL_LAST;
										row_q <= row_q - RW'(1);
									end else begin
										col_q <= col_q - CW'(1);
									end
								end
							end else if (col_q == COL_LAST) begin
								col_q <= '0;
								if (row_q == ROW_LAST) begin
									pos_q    <= pos_q - POS_CLAST;
									scroll_q <= 1'b1;
									state_q  <= ST_SCROLL;
								end else begin
									row_q   <= row_q + RW'(1);
									pos_q   <= pos_q + AW'(1);
									state_q <= ST_FINISH;
								end
							end else begin
								col_q   <= col_q + CW'(1);
								pos_q   <= pos_q + AW'(1);
								state_q <= ST_FINISH;
							end
						end
						tcw_pkg::KIND_CLEAR: begin
							col_q   <= '0;
							row_q   <= '0;
							pos_q   <= '0;
							state_q <= ST_BLANK;
						end
						tcw_pkg::KIND_READ: begin
							if (read_ok) begin
								state_q <= ST_READ;
							end else begin
								state_q <= ST_FINISH;
							end
						end
						default: begin
							state_q <= ST_FINISH;
						end
					endcase
				end
				ST_READ: begin
					data_q  <= ram_rdata;
					state_q <= ST_FINISH;
				end
				ST_SCROLL: begin
					// read one row down, write the cell fetched last cycle
					pend_s1 <= 1'b1;
					wa_s1   <= cnt_q;
					cnt_q   <= cnt_q + AW'(1);
					if (cnt_q == MOVE_LAST) begin
						state_q <= ST_BLANK;
					end
				end
				ST_BLANK: begin
					// finish the last move, then blank up to the end
					if (pend_s1) begin
						pend_s1 <= 1'b0;
					end else if (cnt_q == CELL_LAST) begin
						state_q <= ST_FINISH;
					end else begin
						cnt_q <= cnt_q + AW'(1);
					end
				end
				ST_FINISH: begin
					// load the result word when the output register is free
					if (!m_tvalid_q || m_tready) begin
						m_tvalid_q <= 1'b1;
						m_tdata_q  <= {scroll_q, data_q,
							tcw_pkg::POS_OUT_W'(pos_q),
							tcw_pkg::ROW_OUT_W'(row_q),
							tcw_pkg::COL_OUT_W'(col_q)};
						state_q    <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	// Linear position tracks row and column whenever idle
	a_pos_match: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_IDLE) |->
		(32'(pos_q) == 32'(row_q) * COLS + 32'(col_q)))
		else $error("cursor position out of step with row and column");

	// An accepted word starts execution in the next cycle
	a_accept_exec: assert property (@(posedge clk) disable iff (!arst_n)
		s_accept |=> (state_q == ST_EXEC))
		else $error("accepted word did not start execution");

	// A result word appears only out of the finish state
	a_result_src: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(m_tvalid_q) |-> ($past(state_q) == ST_FINISH))
		else $error("result word raised outside finish");

	// A scroll leaves the cursor on the last row
	a_scroll_row: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_FINISH && scroll_q) |-> (row_q == ROW_LAST))
		else $error("scroll left cursor off the last row");

	// A pending move write exists only while moving or blanking
	a_pend_phase: assert property (@(posedge clk) disable iff (!arst_n)
		pend_s1 |-> (state_q == ST_SCROLL || state_q == ST_BLANK))
		else $error("pending move write outside scroll");

endmodule
